### src/assert_macros.svh
// Assertion macros used by buddy_page_allocator.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BPA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bpa_pkg.sv
// Types, constants and reset image for the buddy page allocator.
package bpa_pkg;

    localparam int PAGE_COUNT  = 4096;
    localparam int ORDER_COUNT = 12;
    localparam int TOP_ORDER   = ORDER_COUNT - 1;
    localparam int TOP_SIZE    = 1 << TOP_ORDER;
    localparam int PAGE_W      = 12;
    localparam int ORD_W       = 4;
    localparam int OIDX_W      = $clog2(ORDER_COUNT);
    localparam int LINK_W      = $clog2(PAGE_COUNT + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGE_COUNT);
    localparam logic [LINK_W-1:0] TOP_HEAD_RST =
        (PAGE_COUNT >= TOP_SIZE) ? LINK_W'(0) : NIL;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OOM   = 2'd1,
        STATUS_DFREE = 2'd2
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [ORD_W-1:0]  req_order;
        logic [PAGE_W-1:0] page_index;
    } bpa_in_t;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] block_page;
        logic [ORD_W-1:0]  block_order;
    } bpa_out_t;

    // One page record: allocated mark, recorded order, list links.
    typedef struct packed {
        logic              alloc;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } page_word_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        A_SEARCH,
        A_HEAD,
        A_NODE,
        A_NEXT_WR,
        A_SPLIT,
        A_PUSH,
        A_PUSH_WR,
        A_FINAL,
        F_START,
        F_CHK,
        F_MERGE,
        F_BUDDY,
        F_N_WR,
        F_P_WR,
        F_PUSH,
        F_PUSH_WR,
        ST_DONE
    } state_t;

    // Page record after reset: whole top blocks chained in ascending order.
    function automatic page_word_t init_word(input logic [PAGE_W-1:0] idx);
        page_word_t w;
        int         i;
        i       = int'(idx);
        w.alloc = 1'b0;
        w.order = '0;
        w.nxt   = NIL;
        w.prv   = NIL;
        if ((i % TOP_SIZE) == 0 && i + TOP_SIZE <= PAGE_COUNT) begin
            w.order = ORD_W'(TOP_ORDER);
            if (i + 2 * TOP_SIZE <= PAGE_COUNT) begin
                w.nxt = LINK_W'(i + TOP_SIZE);
            end
            if (i >= TOP_SIZE) begin
                w.prv = LINK_W'(i - TOP_SIZE);
            end
        end
        return w;
    endfunction

endpackage

### src/bpa_page_ram.sv
// Simple dual-port page record RAM, one write and one registered read port.
module bpa_page_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 31
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/buddy_page_allocator.sv
// Buddy page allocator top level: command sequencer, list heads and page RAM.
//
// Usage:
//   s_valid/s_ready/s_data carry one command item (allocate or free).
//   m_valid/m_ready/m_data carry one result item per command.
//   After aresetn is released the block sweeps the page RAM to write the
//   reset image, one page per cycle, over all PAGE_COUNT (4096) pages with
//   s_ready low. Then s_ready is high whenever the sequencer is idle.
//   Steps from accept to result:
//     allocate: search the lists, read the head and unlink it (fixing its
//       successor's back link), split down to the requested order, pushing
//       each upper half (fixing the old head's back link), then mark the block
//       allocated; out of memory answers straight from the search.
//     free: check the record, probe buddies and unlink each free one, fixing
//       its neighbor links, then push the merged block; double free ends at the check.
//   The worst case is a free that merges all the way up. All link traffic
//   goes through the one page RAM port pair, one read and one write a cycle,
//   which sets the rate.
//   A finished result waits in the output register; a new command is taken
//   while it waits, and the next result is held in the sequencer until the
//   receiver takes the previous one.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bpa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bpa_out_t m_data
);
    `include "assert_macros.svh"

    state_t            state_reg, state_next;
    logic [PAGE_W-1:0] clr_reg, clr_next;
    bpa_in_t           cmd_reg, cmd_next;
    logic [PAGE_W-1:0] node_reg, node_next;   // block being worked on
    logic [ORD_W-1:0]  ord_reg, ord_next;     // current order / list index
    logic [LINK_W-1:0] aux_reg, aux_next;     // buddy or split half
    logic [LINK_W-1:0] n_reg, n_next;
    logic [LINK_W-1:0] p_reg, p_next;
    bpa_out_t          res_reg, res_next;
    bpa_out_t          m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;
    logic [LINK_W-1:0] head_reg  [ORDER_COUNT];
    logic [LINK_W-1:0] head_next [ORDER_COUNT];

    // Page RAM port signals.
    logic              rd_en, wr_en;
    logic [PAGE_W-1:0] rd_addr, wr_addr;
    page_word_t        wr_word, rd_word;
    logic [$bits(page_word_t)-1:0] rd_bits;

    // Lowest non-empty list at or above the requested order.
    logic [ORD_W-1:0]  found;
    logic              any_found;
    logic [LINK_W-1:0] head_cur;
    logic [LINK_W-1:0] split_half;
    logic [LINK_W-1:0] buddy;

    bpa_page_ram #(
        .DEPTH(PAGE_COUNT),
        .WIDTH($bits(page_word_t))
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_word),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_bits)
    );

    assign rd_word = page_word_t'(rd_bits);

    always_comb begin
        found     = '0;
        any_found = 1'b0;
        for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
            if (head_reg[i] < NIL && ORD_W'(i) >= cmd_reg.req_order) begin
                found     = ORD_W'(i);
                any_found = 1'b1;
            end
        end
    end

    assign head_cur   = head_reg[ord_reg[OIDX_W-1:0]];
    assign split_half = {1'b0, node_reg} + (LINK_W'(1) << ord_reg);
    assign buddy      = {1'b0, node_reg ^ (PAGE_W'(1) << ord_reg)};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++) begin
                head_reg[i] <= (i == TOP_ORDER) ? TOP_HEAD_RST : NIL;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        node_reg   <= node_next;
        ord_reg    <= ord_next;
        aux_reg    <= aux_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        node_next    = node_reg;
        ord_next     = ord_reg;
        aux_next     = aux_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        head_next    = head_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_word      = rd_word;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_word  = init_word(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == PAGE_W'(PAGE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = (s_data.cmd == CMD_ALLOC) ? A_SEARCH : F_START;
                end
            end
            // ---------------- allocate ----------------
            A_SEARCH: begin
                if (any_found) begin
                    ord_next   = found;
                    state_next = A_HEAD;
                end else begin
                    res_next   = '{STATUS_OOM, '0, cmd_reg.req_order};
                    state_next = ST_DONE;
                end
            end
            A_HEAD: begin
                node_next  = head_cur[PAGE_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = head_cur[PAGE_W-1:0];
                state_next = A_NODE;
            end
            A_NODE: begin
                n_next = rd_word.nxt;
                head_next[ord_reg[OIDX_W-1:0]] = rd_word.nxt;
                if (rd_word.nxt < NIL) begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_word.nxt[PAGE_W-1:0];
                    state_next = A_NEXT_WR;
                end else begin
                    state_next = A_SPLIT;
                end
            end
            A_NEXT_WR: begin
                wr_en       = 1'b1;
                wr_addr     = n_reg[PAGE_W-1:0];
                wr_word.prv = NIL;
                state_next  = A_SPLIT;
            end
            A_SPLIT: begin
                if (ord_reg > cmd_reg.req_order) begin
                    ord_next   = ord_reg - 1'b1;
                    state_next = A_PUSH;
                end else begin
                    state_next = A_FINAL;
                end
            end
            A_PUSH: begin
                // upper half of the split block goes on the lower list
                state_next = A_SPLIT;
                if (split_half < NIL) begin
                    wr_en    = 1'b1;
                    wr_addr  = split_half[PAGE_W-1:0];
                    wr_word  = '{1'b0, ord_reg, head_cur, NIL};
                    head_next[ord_reg[OIDX_W-1:0]] = split_half;
                    aux_next = split_half;
                    n_next   = head_cur;
                    if (head_cur < NIL) begin
                        rd_en      = 1'b1;
                        rd_addr    = head_cur[PAGE_W-1:0];
                        state_next = A_PUSH_WR;
                    end
                end
            end
            A_PUSH_WR: begin
                wr_en       = 1'b1;
                wr_addr     = n_reg[PAGE_W-1:0];
                wr_word.prv = aux_reg;
                state_next  = A_SPLIT;
            end
            A_FINAL: begin
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_word    = '{1'b1, cmd_reg.req_order, NIL, NIL};
                res_next   = '{STATUS_OK, node_reg, cmd_reg.req_order};
                state_next = ST_DONE;
            end
            // ---------------- free ----------------
            F_START: begin
                node_next = cmd_reg.page_index;
                if ({1'b0, cmd_reg.page_index} >= NIL) begin
                    res_next   = '{STATUS_DFREE, cmd_reg.page_index, '0};
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = cmd_reg.page_index;
                    state_next = F_CHK;
                end
            end
            F_CHK: begin
                if (!rd_word.alloc) begin
                    res_next   = '{STATUS_DFREE, cmd_reg.page_index, '0};
                    state_next = ST_DONE;
                end else begin
                    wr_en         = 1'b1;
                    wr_addr       = node_reg;
                    wr_word.alloc = 1'b0;
                    ord_next      = rd_word.order;
                    state_next    = F_MERGE;
                end
            end
            F_MERGE: begin
                if (ord_reg < ORD_W'(TOP_ORDER) && buddy < NIL) begin
                    aux_next   = buddy;
                    rd_en      = 1'b1;
                    rd_addr    = buddy[PAGE_W-1:0];
                    state_next = F_BUDDY;
                end else begin
                    state_next = F_PUSH;
                end
            end
            F_BUDDY: begin
                if (rd_word.alloc || rd_word.order != ord_reg) begin
                    state_next = F_PUSH;
                end else begin
                    // unlink the buddy from its list
                    n_next      = rd_word.nxt;
                    p_next      = rd_word.prv;
                    wr_en       = 1'b1;
                    wr_addr     = aux_reg[PAGE_W-1:0];
                    wr_word.nxt = NIL;
                    wr_word.prv = NIL;
                    if (rd_word.prv >= NIL && head_cur == aux_reg) begin
                        head_next[ord_reg[OIDX_W-1:0]] = rd_word.nxt;
                    end
                    if (rd_word.nxt < NIL) begin
                        rd_en      = 1'b1;
                        rd_addr    = rd_word.nxt[PAGE_W-1:0];
                        state_next = F_N_WR;
                    end else if (rd_word.prv < NIL) begin
                        rd_en      = 1'b1;
                        rd_addr    = rd_word.prv[PAGE_W-1:0];
                        state_next = F_P_WR;
                    end else begin
                        node_next  = node_reg & ~(PAGE_W'(1) << ord_reg);
                        ord_next   = ord_reg + 1'b1;
                        state_next = F_MERGE;
                    end
                end
            end
            F_N_WR: begin
                wr_en       = 1'b1;
                wr_addr     = n_reg[PAGE_W-1:0];
                wr_word.prv = p_reg;
                if (p_reg < NIL) begin
                    rd_en      = 1'b1;
                    rd_addr    = p_reg[PAGE_W-1:0];
                    state_next = F_P_WR;
                end else begin
                    node_next  = node_reg & ~(PAGE_W'(1) << ord_reg);
                    ord_next   = ord_reg + 1'b1;
                    state_next = F_MERGE;
                end
            end
            F_P_WR: begin
                wr_en       = 1'b1;
                wr_addr     = p_reg[PAGE_W-1:0];
                wr_word.nxt = n_reg;
                node_next   = node_reg & ~(PAGE_W'(1) << ord_reg);
                ord_next    = ord_reg + 1'b1;
                state_next  = F_MERGE;
            end
            F_PUSH: begin
                wr_en    = 1'b1;
                wr_addr  = node_reg;
                wr_word  = '{1'b0, ord_reg, head_cur, NIL};
                head_next[ord_reg[OIDX_W-1:0]] = {1'b0, node_reg};
                n_next   = head_cur;
                res_next = '{STATUS_OK, node_reg, ord_reg};
                if (head_cur < NIL) begin
                    rd_en      = 1'b1;
                    rd_addr    = head_cur[PAGE_W-1:0];
                    state_next = F_PUSH_WR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            F_PUSH_WR: begin
                wr_en       = 1'b1;
                wr_addr     = n_reg[PAGE_W-1:0];
                wr_word.prv = {1'b0, node_reg};
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BPA_ASSERT(a_status_code, aclk, aresetn,
        m_valid |-> (m_data.status == STATUS_OK || m_data.status == STATUS_OOM ||
                     m_data.status == STATUS_DFREE),
        "result status code out of range")
    `BPA_ASSERT(a_idle_no_write, aclk, aresetn,
        (state_reg == ST_IDLE) |-> !wr_en,
        "page RAM written while idle")
    `BPA_ASSERT(a_final_order, aclk, aresetn,
        (state_reg == A_FINAL) |-> (cmd_reg.req_order <= ORD_W'(TOP_ORDER)),
        "allocation completed with order above top")
    `BPA_ASSERT_ALWAYS(a_init_blocks_input,
        aclk, (state_reg == ST_INIT) |-> !s_ready,
        "item accepted during RAM clearing pass")

endmodule

### test/buddy_page_allocator_tb.sv
// Self-checking testbench for the buddy page allocator: random alloc/free traffic.
module buddy_page_allocator_tb
    import bpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 1200;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bpa_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bpa_out_t m_data;

    buddy_page_allocator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the allocator state; NIL is PAGE_COUNT.
    int pg_ord  [PAGE_COUNT];
    bit pg_used [PAGE_COUNT];
    int pg_next [PAGE_COUNT];
    int pg_prev [PAGE_COUNT];
    int free_head [ORDER_COUNT];

    bpa_in_t  cmd_queue [$];   // items waiting for the driver
    bpa_out_t result_queue [$]; // results the block still owes us
    int       live_blocks [$];  // heads currently allocated, for well-formed frees
    int       err_count = 0;
    int       cycle_count = 0;

    function automatic void shadow_reset();
        for (int i = 0; i < PAGE_COUNT; i++) begin
            pg_ord[i]  = 0;
            pg_used[i] = 1'b0;
            pg_next[i] = PAGE_COUNT;
            pg_prev[i] = PAGE_COUNT;
        end
        for (int o = 0; o < ORDER_COUNT; o++) free_head[o] = PAGE_COUNT;
        for (int i = 0; i + TOP_SIZE <= PAGE_COUNT; i += TOP_SIZE) begin
            pg_ord[i] = TOP_ORDER;
            if (i == 0) begin
                free_head[TOP_ORDER] = 0;
            end else begin
                pg_prev[i] = i - TOP_SIZE;
                pg_next[i - TOP_SIZE] = i;
            end
        end
    endfunction

    function automatic void list_push(int o, int p);
        int h;
        h = free_head[o];
        pg_prev[p] = PAGE_COUNT;
        pg_next[p] = h;
        if (h < PAGE_COUNT) pg_prev[h] = p;
        free_head[o] = p;
    endfunction

    function automatic void list_unlink(int o, int p);
        int n, q;
        n = pg_next[p];
        q = pg_prev[p];
        if (n < PAGE_COUNT) pg_prev[n] = q;
        if (q < PAGE_COUNT) pg_next[q] = n;
        else if (free_head[o] == p) free_head[o] = n;
        pg_next[p] = PAGE_COUNT;
        pg_prev[p] = PAGE_COUNT;
    endfunction

    // Applies one command to the shadow state and returns the result the block must give.
    function automatic bpa_out_t buddy_apply(bpa_in_t c);
        bpa_out_t r;
        int req, found, node, s, p, o, bud;
        req = int'(c.req_order);
        p   = int'(c.page_index);
        if (c.cmd == CMD_ALLOC) begin
            found = ORDER_COUNT;
            for (int i = req; i < ORDER_COUNT; i++) begin
                if (free_head[i] < PAGE_COUNT) begin
                    found = i;
                    break;
                end
            end
            if (found >= ORDER_COUNT) begin
                r.status      = STATUS_OOM;
                r.block_page  = '0;
                r.block_order = c.req_order;
                return r;
            end
            node = free_head[found];
            list_unlink(found, node);
            for (int i = found; i > req; i--) begin
                s = node + (1 << (i - 1));
                list_push(i - 1, s);
                pg_ord[s] = i - 1;
            end
            pg_ord[node]  = req;
            pg_used[node] = 1'b1;
            r.status      = STATUS_OK;
            r.block_page  = PAGE_W'(node);
            r.block_order = c.req_order;
            return r;
        end
        if (!pg_used[p]) begin
            r.status      = STATUS_DFREE;
            r.block_page  = c.page_index;
            r.block_order = '0;
            return r;
        end
        pg_used[p] = 1'b0;
        o = pg_ord[p];
        while (o < TOP_ORDER) begin
            bud = p ^ (1 << o);
            if (bud >= PAGE_COUNT || pg_used[bud] || pg_ord[bud] != o) break;
            list_unlink(o, bud);
            if (bud < p) p = bud;
            o++;
        end
        list_push(o, p);
        pg_ord[p]     = o;
        r.status      = STATUS_OK;
        r.block_page  = PAGE_W'(p);
        r.block_order = ORD_W'(o);
        return r;
    endfunction

    // Queues one command with its expected result, and tracks live blocks.
    function automatic void issue(logic cmd, int ord, int page);
        bpa_in_t  c;
        bpa_out_t r;
        c.cmd        = cmd;
        c.req_order  = ORD_W'(ord);
        c.page_index = PAGE_W'(page);
        r = buddy_apply(c);
        cmd_queue.push_back(c);
        result_queue.push_back(r);
        if (r.status == STATUS_OK) begin
            if (cmd == CMD_ALLOC) begin
                live_blocks.push_back(int'(r.block_page));
            end else begin
                for (int k = 0; k < live_blocks.size(); k++) begin
                    if (live_blocks[k] == page) begin
                        live_blocks.delete(k);
                        break;
                    end
                end
            end
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: valid holds until accepted, then the next item or a gap.
    int  src_gap = 0;
    bit  src_burst = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0 && !src_burst) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                s_data  <= cmd_queue.pop_front();
                s_valid <= 1'b1;
                src_gap <= pick_gap();
                if ($urandom_range(0, 63) == 0) src_burst <= ~src_burst;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest expectation.
    int  sink_gap = 0;
    always @(posedge aclk) begin
        bpa_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $error("unexpected result item: %p", m_data);
                    err_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        err_count++;
                    end
                    if (m_data.block_page !== want.block_page) begin
                        $error("block_page: expected %0d, got %0d",
                               want.block_page, m_data.block_page);
                        err_count++;
                    end
                    if (m_data.block_order !== want.block_order) begin
                        $error("block_order: expected %0d, got %0d",
                               want.block_order, m_data.block_order);
                        err_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap();
            end
        end
    end

    // Watchdog; the count covers the post-reset RAM sweep as well.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int roll, pick;
        shadow_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: smallest and largest orders, oversized requests, double frees.
        issue(CMD_ALLOC, 0, 0);          // splits the first top block down to order 0
        issue(CMD_ALLOC, TOP_ORDER, 0);  // takes the second top block, emptying the top list
        issue(CMD_ALLOC, 12, 0);         // order above the top order
        issue(CMD_ALLOC, 15, 0);
        issue(CMD_FREE, 0, 4095);        // inside an allocated block, not a block head
        issue(CMD_FREE, 0, 1);           // free page, head of a free order-0 block
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_ALLOC, 10, 0);
        issue(CMD_FREE, 0, 0);
        issue(CMD_FREE, 0, 0);           // same head twice
        issue(CMD_FREE, 0, 1);           // merges back partially
        issue(CMD_FREE, 0, 2);
        issue(CMD_FREE, 0, 2048);        // top block back on the top list, no merge
        issue(CMD_ALLOC, TOP_ORDER, 0);  // takes that top block again
        issue(CMD_ALLOC, 0, 0);          // served by splitting the order-10 block at page 0
        issue(CMD_FREE, 0, 0);
        issue(CMD_ALLOC, 5, 0);
        issue(CMD_ALLOC, 5, 0);
        issue(CMD_FREE, 0, 32);
        issue(CMD_FREE, 0, 0);

        // Random: well-formed frees of live blocks, more often once over 60 are live,
        // noise frees, oversized requests and allocations that can run the pool dry.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (live_blocks.size() > 0 &&
                (roll < 40 || (live_blocks.size() > 60 && roll < 70))) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                issue(CMD_FREE, 0, live_blocks[pick]);
            end else if (roll < 48) begin
                issue(CMD_FREE, 0, $urandom_range(0, PAGE_COUNT - 1));
            end else if (roll < 51) begin
                issue(CMD_ALLOC, $urandom_range(12, 15),
                      $urandom_range(0, PAGE_COUNT - 1));
            end else if (roll < 58) begin
                issue(CMD_ALLOC, $urandom_range(6, TOP_ORDER),
                      $urandom_range(0, PAGE_COUNT - 1));
            end else begin
                issue(CMD_ALLOC, $urandom_range(0, 5), $urandom_range(0, PAGE_COUNT - 1));
            end
        end

        wait (cmd_queue.size() == 0 && !s_valid && result_queue.size() == 0);
        repeat (60) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
